@@ hw/rtl/dpm_pkg.sv @@
package dpm_pkg;

  // field and register widths
  localparam int LB_W    = 5;
  localparam int CNT_W   = 17;
  localparam int IDX_W   = 16;
  localparam int WORD_W  = 64;
  localparam int SYM_W   = 20;
  localparam int NODE_W  = 16;
  localparam int VERD_W  = 2;
  localparam int CFG_W   = 17;
  localparam int CFG_IDX_W = 1;
  localparam int LBC_W   = 6;

  // defaults for the top-level parameters
  localparam int DEF_EDGE_DEPTH      = 65536;
  localparam int DEF_MAX_LETTER_BITS = 20;

  // register reset values
  localparam int LB_RESET  = 8;
  localparam int CNT_RESET = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LETTER_BITS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_COUNT  = 1'b1;

  // request kinds
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_MATCH = 1'b1;

  // edge flag positions relative to the letter width
  localparam logic [WORD_W-1:0] MARKER_FLAG    = 64'd1;
  localparam logic [WORD_W-1:0] DIRECTION_FLAG = 64'd2;
  localparam logic [WORD_W-1:0] WORD_END_FLAG  = 64'd4;

  typedef enum logic [VERD_W-1:0] {
    VERDICT_LOADED = 2'd0,
    VERDICT_ALIVE  = 2'd1,
    VERDICT_ACCEPT = 2'd2,
    VERDICT_REJECT = 2'd3
  } verdict_t;

  // commands from controller to datapath
  typedef struct packed {
    logic     write;     // store the load request's edge word
    logic     take;      // latch symbol request, scan index from current node
    logic     step;      // move scan index to next edge
    logic     done;      // emit a result
    logic     upd_word;  // update current node and dead flag
    verdict_t verdict;
  } ctrl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic dead;       // word already rejected
    logic node_out;   // scan index at or past edge count
    logic scan_end;   // next scan index at or past edge count
    logic stop;       // sentinel or backward edge
    logic hit;        // letter equals symbol
    logic marker;     // last edge of the node
    logic eow;        // end-of-word bit
    logic next_bad;   // target node zero or outside the table
    logic complete;   // end-of-word required
    logic last;       // symbol ends the word
  } dp_status_t;

endpackage

@@ hw/rtl/dpm_datapath.sv @@
module dpm_datapath #(
  parameter int EDGE_DEPTH      = dpm_pkg::DEF_EDGE_DEPTH,
  parameter int MAX_LETTER_BITS = dpm_pkg::DEF_MAX_LETTER_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [dpm_pkg::IDX_W-1:0]       in_edge_index,
  input  logic [dpm_pkg::WORD_W-1:0]      in_edge_word,
  input  logic [dpm_pkg::SYM_W-1:0]       in_symbol,
  input  logic                            in_need_complete,
  input  logic                            in_last_symbol,
  input  logic                            cfg_we,
  input  logic [dpm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dpm_pkg::CFG_W-1:0]       cfg_wdata,
  input  dpm_pkg::ctrl_cmd_t              cmd,
  output dpm_pkg::dp_status_t             status,
  output logic                            out_strobe,
  output logic [dpm_pkg::VERD_W-1:0]      out_verdict
);
  import dpm_pkg::*;

  localparam int AW = (EDGE_DEPTH > 1) ? $clog2(EDGE_DEPTH) : 1;

  function automatic logic [LBC_W-1:0] clamp_lb(input logic [LB_W-1:0] v);
    logic [LBC_W-1:0] w;
    w = {1'b0, v};
    if (w == '0) w = LBC_W'(1);
    if (w > LBC_W'(MAX_LETTER_BITS)) w = LBC_W'(MAX_LETTER_BITS);
    return w;
  endfunction

  // configuration and word state
  logic [LBC_W-1:0]  lb_r;
  logic [CNT_W-1:0]  count_r;
  logic [NODE_W-1:0] node_r;
  logic              dead_r;
  logic              out_strobe_r;
  logic [VERD_W-1:0] out_verdict_r;

  // scan payload
  logic [CNT_W-1:0]  idx_r;
  logic [SYM_W-1:0]  sym_r;
  logic              complete_r;
  logic              last_r;
  logic [WORD_W-1:0] rd_data_r;

  logic [WORD_W-1:0] mem [EDGE_DEPTH];

  logic [CNT_W-1:0]  count_cfg;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;
  logic              slot_ok;
  logic [LBC_W-1:0]  ns;
  logic [WORD_W-1:0] char_mask;
  logic [WORD_W-1:0] ptr_mask;
  logic [WORD_W-1:0] next_w;
  logic [CNT_W:0]    idx_inc;

  // edge count clamp to table depth
  always_comb begin
    if (32'(cfg_wdata) > 32'(EDGE_DEPTH)) count_cfg = CNT_W'(EDGE_DEPTH);
    else count_cfg = cfg_wdata;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lb_r          <= clamp_lb(LB_W'(LB_RESET));
      count_r       <= CNT_W'(CNT_RESET);
      node_r        <= '0;
      dead_r        <= 1'b0;
      out_strobe_r  <= 1'b0;
      out_verdict_r <= '0;
    end else begin
      if (cfg_we && cfg_index == CFG_LETTER_BITS) lb_r <= clamp_lb(cfg_wdata[LB_W-1:0]);
      if (cfg_we && cfg_index == CFG_EDGE_COUNT) count_r <= count_cfg;
      out_strobe_r  <= cmd.done;
      out_verdict_r <= cmd.verdict;
      if (cmd.done && cmd.upd_word) begin
        if (last_r) begin
          node_r <= '0;
          dead_r <= 1'b0;
        end else if (cmd.verdict == VERDICT_REJECT) begin
          dead_r <= 1'b1;
        end else if (cmd.verdict == VERDICT_ALIVE) begin
          node_r <= next_w[NODE_W-1:0];
        end
      end
    end
  end

  // symbol request and scan index
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      sym_r      <= in_symbol;
      complete_r <= in_need_complete;
      last_r     <= in_last_symbol;
      idx_r      <= {1'b0, node_r};
    end else if (cmd.step) begin
      idx_r <= idx_inc[CNT_W-1:0];
    end
  end

  // edge table, one write and one registered read port
  assign slot_ok = 32'(in_edge_index) < 32'(EDGE_DEPTH);
  assign wr_addr = AW'(in_edge_index);
  assign rd_addr = AW'(idx_r);

  always_ff @(posedge clk) begin
    if (cmd.write && slot_ok) mem[wr_addr] <= in_edge_word;
    rd_data_r <= mem[rd_addr];
  end

  // field decode of the fetched edge
  assign ns          = lb_r + LBC_W'(3);
  assign char_mask   = (64'd1 << lb_r) - 64'd1;
  assign ptr_mask    = ~((64'd1 << ns) - 64'd1);
  assign next_w      = (rd_data_r & ptr_mask) >> ns;
  assign idx_inc     = {1'b0, idx_r} + (CNT_W+1)'(1);

  always_comb begin
    status.dead     = dead_r;
    status.node_out = idx_r >= count_r;
    status.scan_end = idx_inc >= {1'b0, count_r};
    status.stop     = (rd_data_r == ptr_mask) || (|(rd_data_r & (DIRECTION_FLAG << lb_r)));
    status.hit      = (rd_data_r & char_mask) == WORD_W'(sym_r);
    status.marker   = |(rd_data_r & (MARKER_FLAG << lb_r));
    status.eow      = |(rd_data_r & (WORD_END_FLAG << lb_r));
    status.next_bad = (next_w == '0) || (next_w >= WORD_W'(count_r));
    status.complete = complete_r;
    status.last     = last_r;
  end

  assign out_strobe  = out_strobe_r;
  assign out_verdict = out_verdict_r;

endmodule

@@ hw/rtl/dpm_ctrl.sv @@
module dpm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                in_action,
  input  dpm_pkg::dp_status_t status,
  output dpm_pkg::ctrl_cmd_t  cmd,
  output logic                busy
);
  import dpm_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_FETCH,
    ST_EVAL
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  // state and busy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= state_nxt != ST_IDLE;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.verdict  = VERDICT_LOADED;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_action == ACT_LOAD) begin
            cmd.write = 1'b1;
            cmd.done  = 1'b1;
          end else begin
            cmd.take  = 1'b1;
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (status.dead || status.node_out) begin
          cmd.done     = 1'b1;
          cmd.upd_word = 1'b1;
          cmd.verdict  = VERDICT_REJECT;
          state_nxt    = ST_IDLE;
        end else begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        cmd.upd_word = 1'b1;
        state_nxt    = ST_IDLE;
        cmd.done     = 1'b1;
        cmd.verdict  = VERDICT_REJECT;
        if (status.stop) begin
          cmd.verdict = VERDICT_REJECT;
        end else if (status.hit) begin
          if (status.complete && status.last && !status.eow) cmd.verdict = VERDICT_REJECT;
          else if (status.last) cmd.verdict = VERDICT_ACCEPT;
          else if (status.next_bad) cmd.verdict = VERDICT_REJECT;
          else cmd.verdict = VERDICT_ALIVE;
        end else if (!status.marker && !status.scan_end) begin
          // keep scanning siblings
          cmd.done     = 1'b0;
          cmd.upd_word = 1'b0;
          cmd.step     = 1'b1;
          state_nxt    = ST_FETCH;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = busy_r;

endmodule

@@ hw/rtl/dawg_prefix_matcher_top.sv @@
// Word-graph lookup over a 64-bit edge table. A load request (in_action 0)
// writes one edge and is answered by a strobe in the next cycle; busy stays
// low, so another request can follow at once. A symbol request (in_action 1)
// holds busy through a check state, then a fetch and an evaluate state per
// scanned edge (none when the word is already dead or the node is outside the
// table), and its verdict strobes in the cycle busy drops; each edge needs
// both states as the table has one read port with registered data. Results
// show on out_strobe/out_verdict for one cycle only and cannot be held off.
// Configuration may be written only while no request is in progress.
module dawg_prefix_matcher_top #(
  parameter int EDGE_DEPTH      = dpm_pkg::DEF_EDGE_DEPTH,
  parameter int MAX_LETTER_BITS = dpm_pkg::DEF_MAX_LETTER_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_action,
  input  logic [dpm_pkg::IDX_W-1:0]     in_edge_index,
  input  logic [dpm_pkg::WORD_W-1:0]    in_edge_word,
  input  logic [dpm_pkg::SYM_W-1:0]     in_symbol,
  input  logic                          in_need_complete,
  input  logic                          in_last_symbol,
  output logic                          out_strobe,
  output logic [dpm_pkg::VERD_W-1:0]    out_verdict,
  input  logic                          cfg_we,
  input  logic [dpm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dpm_pkg::CFG_W-1:0]     cfg_wdata
);
  import dpm_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencer
  dpm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_action),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy)
  );

  // edge table, word state and result register
  dpm_datapath #(
    .EDGE_DEPTH      (EDGE_DEPTH),
    .MAX_LETTER_BITS (MAX_LETTER_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_edge_index    (in_edge_index),
    .in_edge_word     (in_edge_word),
    .in_symbol        (in_symbol),
    .in_need_complete (in_need_complete),
    .in_last_symbol   (in_last_symbol),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .cmd              (cmd),
    .status           (status),
    .out_strobe       (out_strobe),
    .out_verdict      (out_verdict)
  );

endmodule

@@ hw/rtl/dpm_checker.sv @@
module dpm_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       in_action,
  input logic                       out_strobe,
  input logic [dpm_pkg::VERD_W-1:0] out_verdict
);
  import dpm_pkg::*;

  logic load_req;
  logic match_req;

  assign load_req  = start && !busy && in_action == ACT_LOAD;
  assign match_req = start && !busy && in_action == ACT_MATCH;

  // a load is answered in the next cycle with load done
  a_load_answer: assert property (@(posedge clk) disable iff (!rst_n)
    load_req |=> out_strobe && out_verdict == VERDICT_LOADED)
    else $error("load request not answered in next cycle");

  // a symbol request sets busy in the next cycle, before any result
  a_match_busy: assert property (@(posedge clk) disable iff (!rst_n)
    match_req |=> busy && !out_strobe)
    else $error("symbol request did not raise busy");

  // end of a symbol request always delivers a result
  a_fall_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_strobe && out_verdict != VERDICT_LOADED)
    else $error("busy dropped without a verdict");

  // no result while a request is in progress
  a_no_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobed while busy");

  // load done only follows a load request
  a_loaded_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_verdict == VERDICT_LOADED |-> $past(load_req))
    else $error("load done without a load request");

endmodule

bind dawg_prefix_matcher_top dpm_checker u_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .in_action   (in_action),
  .out_strobe  (out_strobe),
  .out_verdict (out_verdict)
);

@@ dv/testbench.sv @@
module testbench;
  import dpm_pkg::*;

  localparam int EDGE_DEPTH  = DEF_EDGE_DEPTH;
  localparam int MAX_LB      = DEF_MAX_LETTER_BITS;
  localparam int CYCLE_LIMIT = 600000;
  localparam int NUM_PHASES  = 12;
  localparam int NUM_FIXED   = 7;
  localparam int PHASE_ITEMS = 22;

  typedef enum bit {ROW_REQUEST, ROW_CONFIG} row_kind_t;

  typedef struct packed {
    logic               act;
    logic [IDX_W-1:0]   idx;
    logic [WORD_W-1:0]  word;
    logic [SYM_W-1:0]   sym;
    logic               complete;
    logic               last;
  } request_t;

  // config rows carry the register index in idx and the value in word
  typedef struct packed {
    row_kind_t          kind;
    logic               act;
    logic [IDX_W-1:0]   idx;
    logic [WORD_W-1:0]  word;
    logic [SYM_W-1:0]   sym;
    logic               complete;
    logic               last;
    logic               typed;
    verdict_t           verdict;
  } row_t;

  // directed rows, letter width 8: pointer starts at bit 11
  localparam int NUM_ROWS = 35;
  localparam row_t DIRECTED [NUM_ROWS] = '{
    '{ROW_CONFIG, ACT_LOAD, IDX_W'(CFG_LETTER_BITS), 64'd8, 20'd0, 1'b0, 1'b0, 1'b0,
      VERDICT_LOADED},
    '{ROW_CONFIG, ACT_LOAD, IDX_W'(CFG_EDGE_COUNT), 64'd7, 20'd0, 1'b0, 1'b0, 1'b0,
      VERDICT_LOADED},
    // node 0: 'a' -> 2, 'b' -> 3 (marker)
    '{ROW_REQUEST, ACT_LOAD, 16'd0, 64'h1061, 20'd0, 1'b0, 1'b0, 1'b1, VERDICT_LOADED},
    '{ROW_REQUEST, ACT_LOAD, 16'd1, 64'h1962, 20'd0, 1'b0, 1'b0, 1'b1, VERDICT_LOADED},
    // node 2: 'c' -> 0, end of word, marker
    '{ROW_REQUEST, ACT_LOAD, 16'd2, 64'h0563, 20'd0, 1'b0, 1'b0, 1'b1, VERDICT_LOADED},
    // node 3: 'd' -> 5 with end of word, then a sentinel
    '{ROW_REQUEST, ACT_LOAD, 16'd3, 64'h2C64, 20'd0, 1'b0, 1'b0, 1'b1, VERDICT_LOADED},
    '{ROW_REQUEST, ACT_LOAD, 16'd4, 64'hFFFF_FFFF_FFFF_F800, 20'd0, 1'b0, 1'b0, 1'b1,
      VERDICT_LOADED},
    // node 5: backward edge 'e'
    '{ROW_REQUEST, ACT_LOAD, 16'd5, 64'h0A65, 20'd0, 1'b0, 1'b0, 1'b1, VERDICT_LOADED},
    '{ROW_REQUEST, ACT_LOAD, 16'd6, 64'hFFFF_FFFF_FFFF_FFFF, 20'hFFFFF, 1'b1, 1'b1, 1'b1,
      VERDICT_LOADED},
    '{ROW_REQUEST, ACT_LOAD, 16'hFFFF, 64'd0, 20'd0, 1'b0, 1'b0, 1'b1, VERDICT_LOADED},
    // "ac" complete word
    '{ROW_REQUEST, ACT_MATCH, 16'd0, 64'd0, 20'h61, 1'b1, 1'b0, 1'b0, VERDICT_LOADED},
    '{ROW_REQUEST, ACT_MATCH, 16'd0, 64'd0, 20'h63, 1'b1, 1'b1, 1'b0, VERDICT_LOADED},
    // "bde" ends on a backward edge
    '{ROW_REQUEST, ACT_MATCH, 16'd0, 64'd0, 20'h62, 1'b0, 1'b0, 1'b0, VERDICT_LOADED},
    '{ROW_REQUEST, ACT_MATCH, 16'd0, 64'd0, 20'h64, 1'b0, 1'b0, 1'b0, VERDICT_LOADED},
    '{ROW_REQUEST, ACT_MATCH, 16'd0, 64'd0, 20'h65, 1'b0, 1'b1, 1'b0, VERDICT_LOADED},
    // "a" complete, edge lacks end of word
    '{ROW_REQUEST, ACT_MATCH, 16'd0, 64'd0, 20'h61, 1'b1, 1'b1, 1'b0, VERDICT_LOADED},
    // no match, then the dead word answers reject
    '{ROW_REQUEST, ACT_MATCH, 16'd0, 64'd0, 20'h7A, 1'b0, 1'b0, 1'b0, VERDICT_LOADED},
    '{ROW_REQUEST, ACT_MATCH, 16'd0, 64'd0, 20'h61, 1'b0, 1'b1, 1'b1, VERDICT_REJECT},
    // "ac" not finished: node 0 reached early
    '{ROW_REQUEST, ACT_MATCH, 16'd0, 64'd0, 20'h61, 1'b0, 1'b0, 1'b0, VERDICT_LOADED},
    '{ROW_REQUEST, ACT_MATCH, 16'd0, 64'd0, 20'h63, 1'b0, 1'b0, 1'b0, VERDICT_LOADED},
    '{ROW_REQUEST, ACT_MATCH, 16'd0, 64'd0, 20'h63, 1'b0, 1'b1, 1'b1, VERDICT_REJECT},
    // "bx" runs into the sentinel
    '{ROW_REQUEST, ACT_MATCH, 16'd0, 64'd0, 20'h62, 1'b0, 1'b0, 1'b0, VERDICT_LOADED},
    '{ROW_REQUEST, ACT_MATCH, 16'd0, 64'd0, 20'h78, 1'b0, 1'b1, 1'b0, VERDICT_LOADED},
    '{ROW_REQUEST, ACT_MATCH, 16'd0, 64'd0, 20'hFFFFF, 1'b1, 1'b1, 1'b0, VERDICT_LOADED},
    // pointer past the table: counts on the last symbol, kills otherwise
    '{ROW_CONFIG, ACT_LOAD, IDX_W'(CFG_EDGE_COUNT), 64'd4, 20'd0, 1'b0, 1'b0, 1'b0,
      VERDICT_LOADED},
    '{ROW_REQUEST, ACT_MATCH, 16'd0, 64'd0, 20'h62, 1'b0, 1'b0, 1'b0, VERDICT_LOADED},
    '{ROW_REQUEST, ACT_MATCH, 16'd0, 64'd0, 20'h64, 1'b1, 1'b1, 1'b0, VERDICT_LOADED},
    '{ROW_REQUEST, ACT_MATCH, 16'd0, 64'd0, 20'h62, 1'b0, 1'b0, 1'b0, VERDICT_LOADED},
    '{ROW_REQUEST, ACT_MATCH, 16'd0, 64'd0, 20'h64, 1'b0, 1'b0, 1'b0, VERDICT_LOADED},
    '{ROW_REQUEST, ACT_MATCH, 16'd0, 64'd0, 20'h64, 1'b0, 1'b1, 1'b1, VERDICT_REJECT},
    // node left outside the table by a smaller edge count
    '{ROW_REQUEST, ACT_MATCH, 16'd0, 64'd0, 20'h62, 1'b0, 1'b0, 1'b0, VERDICT_LOADED},
    '{ROW_CONFIG, ACT_LOAD, IDX_W'(CFG_EDGE_COUNT), 64'd2, 20'd0, 1'b0, 1'b0, 1'b0,
      VERDICT_LOADED},
    '{ROW_REQUEST, ACT_MATCH, 16'd0, 64'd0, 20'h64, 1'b0, 1'b1, 1'b1, VERDICT_REJECT},
    // empty table
    '{ROW_CONFIG, ACT_LOAD, IDX_W'(CFG_EDGE_COUNT), 64'd0, 20'd0, 1'b0, 1'b0, 1'b0,
      VERDICT_LOADED},
    '{ROW_REQUEST, ACT_MATCH, 16'd0, 64'd0, 20'h61, 1'b0, 1'b1, 1'b1, VERDICT_REJECT}
  };

  localparam int PHASE_LB  [NUM_FIXED] = '{8, 1, 0, 20, 31, 3, 5};
  localparam int PHASE_CNT [NUM_FIXED] = '{40, 24, 30, 64, 50, 65536, 131071};

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 in_action = ACT_LOAD;
  logic [IDX_W-1:0]     in_edge_index = '0;
  logic [WORD_W-1:0]    in_edge_word = '0;
  logic [SYM_W-1:0]     in_symbol = '0;
  logic                 in_need_complete = 1'b0;
  logic                 in_last_symbol = 1'b0;
  logic                 out_strobe;
  logic [VERD_W-1:0]    out_verdict;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // word graph model state
  bit [WORD_W-1:0]      edge_mem [EDGE_DEPTH];
  bit                   written [EDGE_DEPTH];
  logic [NODE_W-1:0]    node_q = '0;
  logic                 dead_q = 1'b0;
  logic [LB_W-1:0]      lb_reg = LB_W'(LB_RESET);
  logic [CNT_W-1:0]     cnt_reg = CNT_W'(CNT_RESET);

  verdict_t             expected_verdicts [$];
  verdict_t             oldest_verdict;
  int                   error_count = 0;
  int                   cycle_count = 0;
  int                   burst_left = 0;
  int                   graph_size = 1;

  dawg_prefix_matcher_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_edge_index    (in_edge_index),
    .in_edge_word     (in_edge_word),
    .in_symbol        (in_symbol),
    .in_need_complete (in_need_complete),
    .in_last_symbol   (in_last_symbol),
    .out_strobe       (out_strobe),
    .out_verdict      (out_verdict),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #6 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (expected_verdicts.size() == 0) begin
        $display("%0t: verdict %0d with no request outstanding", $time, out_verdict);
        error_count++;
      end else begin
        oldest_verdict = expected_verdicts.pop_front();
        if (out_verdict !== oldest_verdict) begin
          $display("%0t: verdict expected %0d actual %0d", $time, oldest_verdict,
                   out_verdict);
          error_count++;
        end
      end
    end
  end

  function automatic int eff_letter_bits();
    int lb;
    lb = int'(lb_reg);
    if (lb < 1) lb = 1;
    if (lb > MAX_LB) lb = MAX_LB;
    return lb;
  endfunction

  function automatic int eff_edge_count();
    return (int'(cnt_reg) > EDGE_DEPTH) ? EDGE_DEPTH : int'(cnt_reg);
  endfunction

  // all pointer bits set, everything below clear
  function automatic logic [WORD_W-1:0] sentinel_word();
    return ~((64'd1 << (eff_letter_bits() + 3)) - 64'd1);
  endfunction

  function automatic logic [WORD_W-1:0] make_edge(input logic [WORD_W-1:0] letter,
      input logic [WORD_W-1:0] flags, input logic [WORD_W-1:0] ptr);
    int lb;
    lb = eff_letter_bits();
    return (ptr << (lb + 3)) | (flags << lb) | (letter & ((64'd1 << lb) - 64'd1));
  endfunction

  // scan the current node for one symbol; hole reports an unwritten slot on the way
  function automatic verdict_t scan_node(input logic [SYM_W-1:0] sym,
      input logic complete, input logic last, output logic [NODE_W-1:0] target,
      output int hole);
    int lb, cnt, i;
    logic [WORD_W-1:0] char_mask, pmask, e, nptr;
    target = node_q;
    hole = -1;
    lb = eff_letter_bits();
    cnt = eff_edge_count();
    char_mask = (64'd1 << lb) - 64'd1;
    pmask = sentinel_word();
    if (int'(node_q) >= cnt) return VERDICT_REJECT;
    for (i = int'(node_q); i < cnt; i++) begin
      if (!written[i]) begin
        hole = i;
        return VERDICT_REJECT;
      end
      e = edge_mem[i];
      if (e == pmask || (e & (DIRECTION_FLAG << lb)) != 0) return VERDICT_REJECT;
      if ((e & char_mask) == WORD_W'(sym)) begin
        nptr = (e & pmask) >> (lb + 3);
        if (complete && last && (e & (WORD_END_FLAG << lb)) == 0) return VERDICT_REJECT;
        if (last) return VERDICT_ACCEPT;
        if (nptr == 0 || nptr >= WORD_W'(cnt)) return VERDICT_REJECT;
        target = nptr[NODE_W-1:0];
        return VERDICT_ALIVE;
      end
      if ((e & (MARKER_FLAG << lb)) != 0) return VERDICT_REJECT;
    end
    return VERDICT_REJECT;
  endfunction

  // verdict of one accepted request, updating the graph model
  function automatic verdict_t predict_request(input request_t r);
    verdict_t v;
    logic [NODE_W-1:0] target;
    int hole;
    if (r.act == ACT_LOAD) begin
      edge_mem[r.idx] = r.word;
      written[r.idx] = 1'b1;
      return VERDICT_LOADED;
    end
    if (dead_q) begin
      v = VERDICT_REJECT;
    end else begin
      v = scan_node(r.sym, r.complete, r.last, target, hole);
      if (v == VERDICT_REJECT) dead_q = 1'b1;
      else if (v == VERDICT_ALIVE) node_q = target;
    end
    if (r.last) begin
      node_q = '0;
      dead_q = 1'b0;
    end
    return v;
  endfunction

  // drive one request in bursts, wait for it to be taken and note its verdict
  task automatic send_request(input request_t r, input bit typed, input verdict_t typed_v);
    verdict_t v;
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 90)
                                               : $urandom_range(1, 12);
    end
    in_action        <= r.act;
    in_edge_index    <= r.idx;
    in_edge_word     <= r.word;
    in_symbol        <= r.sym;
    in_need_complete <= r.complete;
    in_last_symbol   <= r.last;
    start            <= 1'b1;
    do @(posedge clk); while (busy);
    v = predict_request(r);
    expected_verdicts.push_back(typed ? typed_v : v);
    burst_left--;
  endtask

  // stop sending and let every outstanding verdict come back
  task automatic drain_results();
    start <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_index <= idx;
    cfg_wdata <= data;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_LETTER_BITS) lb_reg = data[LB_W-1:0];
    else cnt_reg = data[CNT_W-1:0];
    @(posedge clk);
  endtask

  function automatic request_t load_request(input int slot, input logic [WORD_W-1:0] word);
    request_t r;
    r.act      = ACT_LOAD;
    r.idx      = IDX_W'(slot);
    r.word     = word;
    r.sym      = SYM_W'($urandom);
    r.complete = 1'($urandom_range(0, 1));
    r.last     = 1'($urandom_range(0, 1));
    return r;
  endfunction

  // content for a slot the scan would otherwise read unwritten: always ends the scan
  function automatic request_t filler_load(input int slot);
    logic [WORD_W-1:0] flags;
    flags = MARKER_FLAG;
    if ($urandom_range(0, 1)) flags |= WORD_END_FLAG;
    if ($urandom_range(0, 3) == 0) return load_request(slot, sentinel_word());
    return load_request(slot, make_edge(WORD_W'($urandom_range(0, 7)), flags,
                                        WORD_W'($urandom_range(0, graph_size + 4))));
  endfunction

  // lay out nodes of 1..4 sibling edges in the low slots
  task automatic build_graph();
    int ce, slot, run, j, r;
    logic [WORD_W-1:0] flags, ptr, word;
    ce = eff_edge_count();
    graph_size = (ce < 56) ? ce : $urandom_range(16, 56);
    slot = 0;
    while (slot < graph_size) begin
      run = $urandom_range(1, 4);
      if (slot + run > graph_size) run = graph_size - slot;
      for (j = 0; j < run; j++) begin
        flags = (j == run - 1) ? MARKER_FLAG : '0;
        if ($urandom_range(0, 1)) flags |= WORD_END_FLAG;
        if ($urandom_range(0, 15) == 0) flags |= DIRECTION_FLAG;
        r = $urandom_range(0, 19);
        if (r < 15) ptr = WORD_W'($urandom_range(1, graph_size));
        else if (r < 17) ptr = '0;
        else ptr = {$urandom, $urandom};
        if ($urandom_range(0, 24) == 0) word = sentinel_word();
        else word = make_edge(WORD_W'($urandom_range(0, 5)), flags, ptr);
        send_request(load_request(slot + j, word), 1'b0, VERDICT_LOADED);
      end
      slot += run;
    end
  endtask

  // one word, mostly following letters present at the current node
  task automatic play_word(output int sent);
    int len, pos, hole, pick;
    logic [WORD_W-1:0] mask;
    logic [NODE_W-1:0] target;
    request_t req;
    len = $urandom_range(1, 6);
    sent = 0;
    for (pos = 0; pos < len; pos++) begin
      mask = (64'd1 << eff_letter_bits()) - 64'd1;
      req.act      = ACT_MATCH;
      req.idx      = IDX_W'($urandom);
      req.word     = {$urandom, $urandom};
      req.complete = 1'($urandom_range(0, 1));
      req.last     = (pos == len - 1);
      pick = $urandom_range(0, 19);
      if (pick < 15) begin
        hole = int'(node_q) + $urandom_range(0, 3);
        if (hole < EDGE_DEPTH && written[hole]) req.sym = SYM_W'(edge_mem[hole] & mask);
        else req.sym = SYM_W'($urandom_range(0, 7));
      end else if (pick < 17) begin
        req.sym = SYM_W'($urandom_range(0, 7));
      end else begin
        req.sym = SYM_W'($urandom);
      end
      // patch table slots the scan would reach unwritten
      if (!dead_q) begin
        void'(scan_node(req.sym, req.complete, req.last, target, hole));
        while (hole >= 0) begin
          send_request(filler_load(hole), 1'b0, VERDICT_LOADED);
          void'(scan_node(req.sym, req.complete, req.last, target, hole));
        end
      end
      send_request(req, 1'b0, VERDICT_LOADED);
      sent++;
    end
  endtask

  initial begin
    int r, p, phase_items, sent, slot;
    int lb_val, cnt_val;
    logic [31:0] junk;
    row_t row;
    request_t req;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows
    for (r = 0; r < NUM_ROWS; r++) begin
      row = DIRECTED[r];
      if (row.kind == ROW_CONFIG) begin
        drain_results();
        cfg_write(row.idx[CFG_IDX_W-1:0], row.word[CFG_W-1:0]);
      end else begin
        req = '{row.act, row.idx, row.word, row.sym, row.complete, row.last};
        send_request(req, row.typed, row.verdict);
      end
    end

    // random phases over several register settings
    for (p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      if (p < NUM_FIXED) begin
        lb_val  = PHASE_LB[p];
        cnt_val = PHASE_CNT[p];
      end else begin
        lb_val  = $urandom_range(0, 31);
        cnt_val = $urandom_range(2, 120);
      end
      junk = $urandom;
      cfg_write(CFG_LETTER_BITS, {junk[CFG_W-LB_W-1:0], LB_W'(lb_val)});
      cfg_write(CFG_EDGE_COUNT, CFG_W'(cnt_val));
      build_graph();
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) begin
          // stray load anywhere in the table
          slot = ($urandom_range(0, 2) == 0) ? $urandom_range(0, graph_size)
                                             : $urandom_range(0, EDGE_DEPTH - 1);
          send_request(load_request(slot, {$urandom, $urandom}), 1'b0, VERDICT_LOADED);
          phase_items++;
        end else begin
          play_word(sent);
          phase_items += sent;
        end
        if ($urandom_range(0, 39) == 0) drain_results();
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
